[sv/lexeme_position_list_parser_unit_defines.svh]
`ifndef LEXEME_POSITION_LIST_PARSER_UNIT_DEFINES_SVH
`define LEXEME_POSITION_LIST_PARSER_UNIT_DEFINES_SVH

// Concurrent checks on the rising edge, held off during reset.
`ifndef ASSERT_OFF
`define LPLP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lplp check failed");
`define LPLP_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lplp forbidden condition");
`else
`define LPLP_ASSERT(label, clk, rst_n, prop)
`define LPLP_NEVER(label, clk, rst_n, cond)
`endif

`endif

[sv/lplp_pkg.sv]
package lplp_pkg;

  localparam int MAX_TEXT_LEN = 65536;
  localparam logic [15:0] IDX_LIMIT =
    16'((MAX_TEXT_LEN - 1 > 65535) ? 65535 : (MAX_TEXT_LEN - 1));

  localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;
  localparam int MAX_TOKENS = 3;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [1:0] WEIGHT_D = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    TK_CHAR = 2'd0,
    TK_POS  = 2'd1,
    TK_END  = 2'd2,
    TK_ERR  = 2'd3
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_BETWEEN    = 3'd0,
    MODE_LEXEME     = 3'd1,
    MODE_NEED_DIGIT = 3'd2,
    MODE_DIGITS     = 3'd3,
    MODE_WEIGHTED   = 3'd4
  } mode_t;

  // Tokens caused by one byte; the payload fields are shared because a
  // byte never yields more than one char, one position or one error.
  typedef struct packed {
    logic [1:0]                  cnt;
    tok_kind_t [MAX_TOKENS-1:0]  kind;
    logic [7:0]                  ch;
    logic [30:0]                 pos;
    logic [1:0]                  weight;
    logic [15:0]                 offset;
  } bundle_t;

endpackage

[sv/lplp_front.sv]
module lplp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        text_byte,
  input  logic              is_final,
  output logic              push,
  output lplp_pkg::bundle_t push_data
);

  lplp_pkg::mode_t mode_r, mode_nxt;
  logic [30:0]     accum_r, accum_nxt;
  logic [15:0]     idx_r, idx_nxt;
  logic            err_r, err_nxt;

  logic is_dig, is_up, is_low, is_sp, is_lex, is_wt;
  logic do_between;
  logic [34:0] prod;
  logic [3:0]  digit;
  lplp_pkg::bundle_t b;

  function automatic lplp_pkg::bundle_t add_tok(lplp_pkg::bundle_t l,
                                                lplp_pkg::tok_kind_t k);
    lplp_pkg::bundle_t r;
    r = l;
    if (l.cnt != 2'(lplp_pkg::MAX_TOKENS)) begin
      r.kind[l.cnt] = k;
      r.cnt = l.cnt + 2'd1;
    end
    return r;
  endfunction

  assign is_dig = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign is_up  = (text_byte >= 8'h41) && (text_byte <= 8'h5A);
  assign is_low = (text_byte >= 8'h61) && (text_byte <= 8'h7A);
  assign is_sp  = (text_byte == 8'h20) || ((text_byte >= 8'h09) && (text_byte <= 8'h0D));
  assign is_lex = is_dig || is_up || is_low || (text_byte == lplp_pkg::CH_UNDER);
  assign is_wt  = (text_byte >= lplp_pkg::CH_A) && (text_byte <= lplp_pkg::CH_D);
  assign digit  = text_byte[3:0];
  assign prod   = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) + 35'(digit);

  always_comb begin
    mode_nxt   = mode_r;
    accum_nxt  = accum_r;
    err_nxt    = err_r;
    idx_nxt    = idx_r;
    do_between = 1'b0;
    b          = '0;
    b.ch       = is_up ? text_byte + 8'd32 : text_byte;
    b.pos      = accum_r;
    b.weight   = lplp_pkg::WEIGHT_D;
    b.offset   = idx_r;
    if (!err_r) begin
      unique case (mode_r)
        lplp_pkg::MODE_LEXEME: begin
          if (is_lex) begin
            b = add_tok(b, lplp_pkg::TK_CHAR);
          end else if (text_byte == lplp_pkg::CH_COLON) begin
            mode_nxt = lplp_pkg::MODE_NEED_DIGIT;
          end else begin
            b = add_tok(b, lplp_pkg::TK_END);
            do_between = 1'b1;
          end
        end
        lplp_pkg::MODE_NEED_DIGIT: begin
          if (is_dig) begin
            accum_nxt = 31'(digit);
            mode_nxt  = lplp_pkg::MODE_DIGITS;
          end else begin
            b = add_tok(b, lplp_pkg::TK_ERR);
            err_nxt = 1'b1;
          end
        end
        lplp_pkg::MODE_DIGITS: begin
          if (is_dig) begin
            accum_nxt = (prod > 35'(lplp_pkg::POS_MAX)) ? lplp_pkg::POS_MAX : prod[30:0];
          end else if (is_wt) begin
            b.weight = text_byte[1:0] - lplp_pkg::CH_A[1:0];
            b = add_tok(b, lplp_pkg::TK_POS);
            mode_nxt = lplp_pkg::MODE_WEIGHTED;
          end else begin
            b = add_tok(b, lplp_pkg::TK_POS);
            if (text_byte == lplp_pkg::CH_COMMA) begin
              mode_nxt = lplp_pkg::MODE_NEED_DIGIT;
            end else begin
              b = add_tok(b, lplp_pkg::TK_END);
              do_between = 1'b1;
            end
          end
        end
        lplp_pkg::MODE_WEIGHTED: begin
          if (text_byte == lplp_pkg::CH_COMMA) begin
            mode_nxt = lplp_pkg::MODE_NEED_DIGIT;
          end else begin
            b = add_tok(b, lplp_pkg::TK_END);
            do_between = 1'b1;
          end
        end
        default: do_between = 1'b1;
      endcase
      if (do_between) begin
        mode_nxt = lplp_pkg::MODE_BETWEEN;
        if (is_lex) begin
          b = add_tok(b, lplp_pkg::TK_CHAR);
          mode_nxt = lplp_pkg::MODE_LEXEME;
        end else if (!is_sp) begin
          b = add_tok(b, lplp_pkg::TK_ERR);
          err_nxt = 1'b1;
        end
      end
      if (!err_nxt && is_final) begin
        if (mode_nxt == lplp_pkg::MODE_DIGITS) begin
          b.pos    = accum_nxt;
          b.weight = lplp_pkg::WEIGHT_D;
          b = add_tok(b, lplp_pkg::TK_POS);
        end
        if (mode_nxt != lplp_pkg::MODE_BETWEEN) begin
          b = add_tok(b, lplp_pkg::TK_END);
        end
      end
    end
    if (is_final) begin
      mode_nxt  = lplp_pkg::MODE_BETWEEN;
      accum_nxt = '0;
      idx_nxt   = '0;
      err_nxt   = 1'b0;
    end else if (idx_r < lplp_pkg::IDX_LIMIT) begin
      idx_nxt = idx_r + 16'd1;
    end
  end

  assign push      = accept && (b.cnt != 2'd0);
  assign push_data = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lplp_pkg::MODE_BETWEEN;
      accum_r <= '0;
      idx_r   <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

[sv/lplp_queue.sv]
`include "lexeme_position_list_parser_unit_defines.svh"

module lplp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lplp_pkg::bundle_t push_data,
  output logic              full,
  input  logic              pop,
  output lplp_pkg::bundle_t head,
  output logic              empty
);

  lplp_pkg::bundle_t                 mem_r [lplp_pkg::QDEPTH];
  logic [lplp_pkg::QPTR_W-1:0]       wptr_r, wptr_nxt;
  logic [lplp_pkg::QPTR_W-1:0]       rptr_r, rptr_nxt;
  logic [lplp_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == lplp_pkg::QCNT_W'(lplp_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + lplp_pkg::QCNT_W'(push) - lplp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  `LPLP_NEVER(a_no_push_full, clk, rst_n, push && full)
  `LPLP_NEVER(a_no_pop_empty, clk, rst_n, pop && empty)
  `LPLP_ASSERT(a_cnt_drop, clk, rst_n, (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))

endmodule

[sv/lplp_back.sv]
module lplp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lplp_pkg::bundle_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_token_kind,
  output logic [7:0]        out_lexeme_char,
  output logic [30:0]       out_position_value,
  output logic [1:0]        out_weight_code,
  output logic [15:0]       out_error_offset,
  output logic              out_run_last
);

  logic [1:0]          sel_r, sel_nxt;
  logic                vld_r, vld_nxt;
  logic [1:0]          kind_r;
  logic [7:0]          ch_r;
  logic [30:0]         pos_r;
  logic [1:0]          wt_r;
  logic [15:0]         off_r;
  logic                last_r;
  logic                load, slot_last;
  lplp_pkg::tok_kind_t k;

  assign load      = !vld_r || out_ready;
  assign k         = head.kind[sel_r];
  assign slot_last = (sel_r == head.cnt - 2'd1);
  assign pop       = load && !empty && slot_last;

  always_comb begin
    vld_nxt = vld_r;
    sel_nxt = sel_r;
    if (load) begin
      vld_nxt = !empty;
      if (!empty) begin
        sel_nxt = slot_last ? 2'd0 : sel_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      kind_r <= k;
      ch_r   <= (k == lplp_pkg::TK_CHAR) ? head.ch : 8'd0;
      pos_r  <= (k == lplp_pkg::TK_POS) ? head.pos : 31'd0;
      wt_r   <= (k == lplp_pkg::TK_POS) ? head.weight : 2'd0;
      off_r  <= (k == lplp_pkg::TK_ERR) ? head.offset : 16'd0;
      last_r <= slot_last;
    end
  end

  assign out_valid          = vld_r;
  assign out_token_kind     = kind_r;
  assign out_lexeme_char    = ch_r;
  assign out_position_value = pos_r;
  assign out_weight_code    = wt_r;
  assign out_error_offset   = off_r;
  assign out_run_last       = last_r;

endmodule

[sv/lexeme_position_list_parser_unit.sv]
// A byte's tokens pass through the queue and then the output register to out_valid.
// Throughput: one byte per cycle in while the queue has room; one token per cycle
// out while out_ready is high; a 4-entry queue of bundles absorbs bursts.
// Reset: synchronous active-low rst_n clears parser mode, accumulator, byte
// index, error flag, queue and output valid; the parser also resets per string.
module lexeme_position_list_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_is_final,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_token_kind,
  output logic [7:0]  out_lexeme_char,
  output logic [30:0] out_position_value,
  output logic [1:0]  out_weight_code,
  output logic [15:0] out_error_offset,
  output logic        out_run_last
);

  logic              accept;
  logic              push, pop, q_full, q_empty;
  lplp_pkg::bundle_t push_data, head;

  // Take a word whenever the queue has room, even with the output stalled.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Front: classify the byte, advance the parse mode, bundle its tokens.
  lplp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_text_byte),
    .is_final  (in_is_final),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: hold bundles so the parser and the token drain stall on their own.
  lplp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // Back: drain each bundle one token per word into the output register.
  lplp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .empty              (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_token_kind     (out_token_kind),
    .out_lexeme_char    (out_lexeme_char),
    .out_position_value (out_position_value),
    .out_weight_code    (out_weight_code),
    .out_error_offset   (out_error_offset),
    .out_run_last       (out_run_last)
  );

endmodule

[tb/tb_lexeme_position_list_parser_unit.sv]
module tb_lexeme_position_list_parser_unit;

  // Give up when no word moves on either channel for this many cycles.
  localparam int STALL_LIMIT = 2000;
  // Cycles to wait at the end for late or extra tokens to show up.
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_WORDS = 270;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LOW_A = 8'h61;

  // One token as seen on the result channel.
  typedef struct packed {
    lplp_pkg::tok_kind_t kind;
    logic [7:0]          ch;
    logic [30:0]         pos;
    logic [1:0]          weight;
    logic [15:0]         offset;
    logic                last;
  } lex_token_t;

  // Tracks the parser state for every accepted byte and keeps the tokens
  // the block still owes, oldest first.
  class lexeme_token_scoreboard;
    lplp_pkg::mode_t parse_state;
    logic [30:0]     pos_acc;
    logic [15:0]     offset_ctr;
    bit              err_seen;
    lex_token_t      owed_q[$];
    lex_token_t      step_q[$];
    int              mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      parse_state = lplp_pkg::MODE_BETWEEN;
      pos_acc     = '0;
      offset_ctr  = '0;
      err_seen    = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= 8'h39;
    endfunction

    function bit is_upper(logic [7:0] c);
      return c >= CH_UP_A && c <= 8'h5A;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= 8'h0D);
    endfunction

    function bit is_lex(logic [7:0] c);
      return is_digit(c) || is_upper(c) || (c >= CH_LOW_A && c <= 8'h7A) ||
             c == lplp_pkg::CH_UNDER;
    endfunction

    // A byte yields at most three tokens; anything past that is dropped.
    function void add_token(lplp_pkg::tok_kind_t k, logic [7:0] ch, logic [30:0] pos,
                            logic [1:0] w, logic [15:0] off);
      lex_token_t t;
      if (step_q.size() >= lplp_pkg::MAX_TOKENS) return;
      t.kind   = k;
      t.ch     = ch;
      t.pos    = pos;
      t.weight = w;
      t.offset = off;
      t.last   = 1'b0;
      step_q = {step_q, t};
    endfunction

    function void add_char(logic [7:0] c);
      add_token(lplp_pkg::TK_CHAR, is_upper(c) ? c + 8'd32 : c, '0, '0, '0);
    endfunction

    function void flag_error();
      add_token(lplp_pkg::TK_ERR, '0, '0, '0, offset_ctr);
      err_seen = 1'b1;
    endfunction

    function void start_entry(logic [7:0] c);
      parse_state = lplp_pkg::MODE_BETWEEN;
      if (is_space(c)) return;
      if (is_lex(c)) begin
        add_char(c);
        parse_state = lplp_pkg::MODE_LEXEME;
      end else begin
        flag_error();
      end
    endfunction

    function void advance(logic [7:0] c);
      logic [34:0] grown;
      case (parse_state)
        lplp_pkg::MODE_LEXEME: begin
          if (is_lex(c)) begin
            add_char(c);
          end else if (c == lplp_pkg::CH_COLON) begin
            parse_state = lplp_pkg::MODE_NEED_DIGIT;
          end else begin
            add_token(lplp_pkg::TK_END, '0, '0, '0, '0);
            start_entry(c);
          end
        end
        lplp_pkg::MODE_NEED_DIGIT: begin
          if (is_digit(c)) begin
            pos_acc     = 31'(c - CH_ZERO);
            parse_state = lplp_pkg::MODE_DIGITS;
          end else begin
            flag_error();
          end
        end
        lplp_pkg::MODE_DIGITS: begin
          if (is_digit(c)) begin
            grown   = 35'(pos_acc) * 35'd10 + 35'(c - CH_ZERO);
            pos_acc = (grown > 35'(lplp_pkg::POS_MAX)) ? lplp_pkg::POS_MAX : grown[30:0];
          end else if (c >= lplp_pkg::CH_A && c <= lplp_pkg::CH_D) begin
            add_token(lplp_pkg::TK_POS, '0, pos_acc, 2'(c - lplp_pkg::CH_A), '0);
            parse_state = lplp_pkg::MODE_WEIGHTED;
          end else begin
            add_token(lplp_pkg::TK_POS, '0, pos_acc, lplp_pkg::WEIGHT_D, '0);
            if (c == lplp_pkg::CH_COMMA) begin
              parse_state = lplp_pkg::MODE_NEED_DIGIT;
            end else begin
              add_token(lplp_pkg::TK_END, '0, '0, '0, '0);
              start_entry(c);
            end
          end
        end
        lplp_pkg::MODE_WEIGHTED: begin
          if (c == lplp_pkg::CH_COMMA) begin
            parse_state = lplp_pkg::MODE_NEED_DIGIT;
          end else begin
            add_token(lplp_pkg::TK_END, '0, '0, '0, '0);
            start_entry(c);
          end
        end
        default: start_entry(c);
      endcase
    endfunction

    function void note_byte(logic [7:0] c, logic fin);
      step_q.delete();
      if (!err_seen) begin
        advance(c);
        if (!err_seen && fin) begin
          if (parse_state == lplp_pkg::MODE_DIGITS)
            add_token(lplp_pkg::TK_POS, '0, pos_acc, lplp_pkg::WEIGHT_D, '0);
          if (parse_state != lplp_pkg::MODE_BETWEEN)
            add_token(lplp_pkg::TK_END, '0, '0, '0, '0);
        end
      end
      if (fin) begin
        clear_state();
      end else if (offset_ctr < lplp_pkg::IDX_LIMIT) begin
        offset_ctr++;
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      owed_q = {owed_q, step_q};
    endfunction

    function void report(string why, lex_token_t want, lex_token_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("token mismatch (%s): expected kind=%0d ch=%h pos=%0d w=%0d off=%0d last=%b",
                 why, want.kind, want.ch, want.pos, want.weight, want.offset, want.last);
        $display("                      got kind=%0d ch=%h pos=%0d w=%0d off=%0d last=%b",
                 got.kind, got.ch, got.pos, got.weight, got.offset, got.last);
      end
    endfunction

    function void check_token(lex_token_t got);
      lex_token_t want;
      if (owed_q.size() == 0) begin
        report("nothing owed", '0, got);
        return;
      end
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.ch !== want.ch || got.pos !== want.pos ||
          got.weight !== want.weight || got.offset !== want.offset ||
          got.last !== want.last)
        report("field", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = '0;
  logic        in_is_final = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_token_kind;
  logic [7:0]  out_lexeme_char;
  logic [30:0] out_position_value;
  logic [1:0]  out_weight_code;
  logic [15:0] out_error_offset;
  logic        out_run_last;

  lexeme_token_scoreboard sb;
  logic [7:0] text_q[$];
  int tx_idle_max = 3;
  int rx_idle_max = 3;
  int rx_hold_req = 0;
  int rx_stall_left = 0;
  int quiet_cycles = 0;
  int live_words = 0;

  lexeme_position_list_parser_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_byte       (in_text_byte),
    .in_is_final        (in_is_final),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_token_kind     (out_token_kind),
    .out_lexeme_char    (out_lexeme_char),
    .out_position_value (out_position_value),
    .out_weight_code    (out_weight_code),
    .out_error_offset   (out_error_offset),
    .out_run_last       (out_run_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Result side: check each word taken, then draw a stall for the next one.
  // A hold request from the main flow overrides the draw and starves the
  // output long enough for the internal queue to fill and push back.
  always @(posedge clk) begin : rx_side
    lex_token_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.kind   = lplp_pkg::tok_kind_t'(out_token_kind);
        got.ch     = out_lexeme_char;
        got.pos    = out_position_value;
        got.weight = out_weight_code;
        got.offset = out_error_offset;
        got.last   = out_run_last;
        sb.check_token(got);
        rx_stall_left = $urandom_range(0, rx_idle_max);
      end
      if (rx_hold_req > 0) begin
        rx_stall_left = rx_hold_req;
        rx_hold_req   = 0;
      end
    end
    if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any accepted word on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one byte after a random gap and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_is_final  <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    live_words++;
    sb.note_byte(b, fin);
  endtask

  // Send the staged string; the last byte carries the final flag.
  task automatic send_queued();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q = {text_q, 8'(s[i])};
    send_queued();
  endtask

  // Drop valid and wait until every owed token has come back.
  task automatic wait_tokens_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.owed_q.size() > 0);
  endtask

  function automatic logic [7:0] pick_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
  endfunction

  function automatic logic [7:0] pick_lex_char();
    case ($urandom_range(0, 3))
      0: return 8'(CH_ZERO + $urandom_range(0, 9));
      1: return 8'(CH_UP_A + $urandom_range(0, 25));
      2: return 8'(CH_LOW_A + $urandom_range(0, 25));
      default: return lplp_pkg::CH_UNDER;
    endcase
  endfunction

  // Mostly well-formed literals: entries of lexeme chars with optional
  // position lists and weights. Now and then a byte is replaced by noise
  // or a stray byte is tacked on to break the grammar.
  function automatic void build_random_text();
    int n_ent;
    int n_pos;
    int n_dig;
    text_q.delete();
    n_ent = $urandom_range(1, 4);
    if ($urandom_range(0, 3) == 0) text_q = {text_q, pick_space()};
    for (int e = 0; e < n_ent; e++) begin
      if (e > 0) repeat ($urandom_range(1, 2)) text_q = {text_q, pick_space()};
      repeat ($urandom_range(1, 4)) text_q = {text_q, pick_lex_char()};
      if ($urandom_range(0, 9) < 6) begin
        text_q = {text_q, lplp_pkg::CH_COLON};
        n_pos = $urandom_range(1, 3);
        // Last entry may end on a bare colon.
        if (e == n_ent - 1 && $urandom_range(0, 9) == 0) n_pos = 0;
        for (int p = 0; p < n_pos; p++) begin
          if (p > 0) text_q = {text_q, lplp_pkg::CH_COMMA};
          n_dig = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
          repeat (n_dig) text_q = {text_q, 8'(CH_ZERO + $urandom_range(0, 9))};
          if ($urandom_range(0, 9) < 4)
            text_q = {text_q, 8'(lplp_pkg::CH_A + $urandom_range(0, 3))};
        end
        if (e == n_ent - 1 && n_pos > 0 && $urandom_range(0, 9) == 0)
          text_q = {text_q, lplp_pkg::CH_COMMA};
      end
    end
    if ($urandom_range(0, 4) == 0) text_q = {text_q, pick_space()};
    if ($urandom_range(0, 4) == 0)
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) text_q = {text_q, 8'($urandom_range(0, 255))};
  endfunction

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: case folding, every weight, second weight, text right after
    // a position, saturating position, trailing colon and comma.
    send_text("Az_9:07,3B c:1Dd");
    send_text("x:5A,99999999999C");
    send_text("y:3,");
    send_text("q:");
    send_text("t:4CD");
    send_text("m:7k n");
    // Final byte that closes a position and opens a one-char entry.
    send_text("p:5x");
    // Missing digit after colon, and a colon right after the digit run.
    send_text("w:x");
    send_text("a:1:");
    // Every whitespace byte, then a bad start; the rest is skipped.
    text_q = '{CH_TAB, 8'h0A, 8'h0B, 8'h0C, 8'h0D, CH_SPACE, 8'hFF, 8'h80};
    send_queued();
    // High byte right after a lexeme ends the entry and then errors.
    text_q = '{8'h62, 8'h80};
    send_queued();
    send_text("!");
    send_text("z");
    send_text(" ");
    wait_tokens_drained();

    // Starve the output while bytes keep coming, then let it drain.
    tx_idle_max = 0;
    rx_hold_req = 64;
    send_text("abcdefghijklmnopQRST:1,2,3");
    wait_tokens_drained();

    // Random literals; some stretches run with no gaps on either side.
    live_words = 0;
    for (int n = 0; live_words < RANDOM_WORDS; n++) begin
      tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
      rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
      build_random_text();
      send_queued();
      if (n % 8 == 7) wait_tokens_drained();
    end
    wait_tokens_drained();

    tx_idle_max = 3;
    rx_idle_max = 3;
    send_text("ok:12B");
    wait_tokens_drained();

    // Give late or extra tokens a chance to show up.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/lplp_pkg.sv
sv/lplp_front.sv
sv/lplp_queue.sv
sv/lplp_back.sv
sv/lexeme_position_list_parser_unit.sv
tb/tb_lexeme_position_list_parser_unit.sv
